[hw/rtl/bfk_pkg.sv]
package bfk_pkg;

	localparam int IDX_W   = 10;
	localparam int EIDX_W  = 7;
	localparam int ELEM_W  = 8;
	localparam int DIST_W  = 23;
	localparam int SQ_W    = 2 * ELEM_W;

	localparam logic [DIST_W-1:0] DIST_MAX = 23'd8388607;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 2'd2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// one finished distance headed for the best list
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  idx;
	} cand_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  idx;
	} entry_t;

endpackage

[hw/rtl/brute_force_knn_l2_top.sv]
// Exhaustive k-nearest-neighbor search, squared Euclidean distance, 8-bit data.
//
// Input stream (s_*): one beat per item. tuser = action. A write beat stores
// one element. A query beat names vector q; unless k is 0 or no vector is
// left to scan, the block then drops s_tready and scans every vector in use
// except q, one element per cycle through one multiply-accumulate fed by the
// two read ports of the vector store; with dim = 0 each vector is still
// visited once, at distance zero.
// Output stream (m_*): min(k, n-1) beats (min(k, n) when q >= n) in ascending
// distance, ties to the lower index, tlast on the final one. A query that
// finds nothing gives no beat. A stall on m_tready just holds the current
// beat; s_tready stays low until the last result beat is taken.
// Config port: cfg_index/cfg_data, always ready; write only while idle.
// Reset: registers return to vector_count 1024, dimension 128,
// neighbor_count 10; the store is not cleared, no read-before-write.
module brute_force_knn_l2_top import bfk_pkg::*; #(
	parameter int MAX_VECTORS = 1024,
	parameter int MAX_DIM     = 128,
	parameter int MAX_K       = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [9:0] vector_index, [16:10] element_index, [24:17] element_value
	input  logic [31:0]           s_tdata,
	// [0] action
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [9:0] neighbor_index, [32:10] squared_distance
	output logic [39:0]           m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_VECTORS * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(MAX_VECTORS + 2);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int EW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int HW    = $clog2(MAX_K + 1);
	localparam int ACC_RAW = $clog2(MAX_DIM * 65025 + 1);
	localparam int ACC_W = (ACC_RAW > DIST_W) ? ACC_RAW : DIST_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// config registers
	logic [10:0] vector_count_q;
	logic [7:0]  dimension_q;
	logic [4:0]  neighbor_count_q;

	logic [NW-1:0] n_eff;
	logic [DW-1:0] dim_eff;
	logic [HW-1:0] k_eff;

	// input fields
	logic              in_action;
	logic [IDX_W-1:0]  in_vidx;
	logic [EIDX_W-1:0] in_eidx;
	logic [ELEM_W-1:0] in_eval;

	// sequencer
	state_t         state_q;
	logic [NW-1:0]  q_q;
	logic [NW-1:0]  j_q;
	logic [EW-1:0]  e_q;
	logic [AW-1:0]  qbase_q;
	logic [AW-1:0]  jbase_q;
	logic [HW-1:0]  r_q;
	logic           out_valid_q;
	logic           out_last_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [DIST_W-1:0] out_dist_q;

	logic          accept;
	logic          query_go;
	logic          in_range;
	logic          issue;
	logic          use_elem;
	logic          vec_last;
	logic [NW-1:0] j_inc;
	logic          skip;
	logic [NW-1:0] j_next;
	logic [AW-1:0] jbase_next;
	logic [NW-1:0] j_start;
	logic          pipe_empty;

	// store
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ra_addr;
	logic [AW-1:0]     rb_addr;
	logic [ELEM_W-1:0] ra_data;
	logic [ELEM_W-1:0] rb_data;

	// datapath
	logic             valid_s1, use_s1, last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             valid_s2, last_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [SQ_W-1:0]  sq_s2;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_sum;
	cand_t            cand_s3;
	logic [ELEM_W:0]  diff;
	logic [ELEM_W-1:0] mag;

	entry_t         best_rd;
	logic [HW-1:0]  held;
	logic [KW-1:0]  rd_sel;

	assign in_action = s_tuser[0];
	assign in_vidx   = s_tdata[9:0];
	assign in_eidx   = s_tdata[16:10];
	assign in_eval   = s_tdata[24:17];

	// saturated register values
	assign n_eff   = (32'(vector_count_q) > MAX_VECTORS) ? NW'(MAX_VECTORS)
	                                                     : NW'(vector_count_q);
	assign dim_eff = (32'(dimension_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dimension_q);
	assign k_eff   = (32'(neighbor_count_q) > MAX_K) ? HW'(MAX_K) : HW'(neighbor_count_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_count_q   <= 11'd1024;
			dimension_q      <= 8'd128;
			neighbor_count_q <= 5'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VECTOR_COUNT:   vector_count_q   <= cfg_data;
				CFG_DIMENSION:      dimension_q      <= cfg_data[7:0];
				CFG_NEIGHBOR_COUNT: neighbor_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign query_go = accept && (in_action == ACT_QUERY);

	// element writes go straight into the store; out-of-range ones drop
	assign ram_we    = accept && (in_action == ACT_WRITE) &&
	                   (32'(in_vidx) < MAX_VECTORS) && (32'(in_eidx) < MAX_DIM);
	assign ram_waddr = AW'(32'(in_vidx) * MAX_DIM + 32'(in_eidx));

	assign in_range = (32'(in_vidx) < MAX_VECTORS) && (k_eff != '0);
	assign j_start  = (in_vidx == '0) ? NW'(1) : NW'(0);

	// scan walk: element counter inside vector counter, q itself skipped
	assign issue    = (state_q == ST_RUN);
	assign use_elem = (dim_eff != '0);
	assign vec_last = !use_elem || (DW'(e_q) + DW'(1) == dim_eff);
	assign j_inc    = j_q + NW'(1);
	assign skip     = (j_inc == q_q);
	assign j_next   = skip ? j_q + NW'(2) : j_inc;
	assign jbase_next = skip ? jbase_q + AW'(2 * MAX_DIM) : jbase_q + AW'(MAX_DIM);

	assign ra_addr = qbase_q + AW'(e_q);
	assign rb_addr = jbase_q + AW'(e_q);

	assign pipe_empty = !valid_s1 && !valid_s2 && !cand_s3.valid;
	assign rd_sel     = r_q[KW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			q_q         <= '0;
			j_q         <= '0;
			e_q         <= '0;
			qbase_q     <= '0;
			jbase_q     <= '0;
			r_q         <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_idx_q   <= '0;
			out_dist_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (query_go && in_range) begin
						q_q     <= NW'(in_vidx);
						j_q     <= j_start;
						e_q     <= '0;
						r_q     <= '0;
						qbase_q <= AW'(32'(in_vidx) * MAX_DIM);
						jbase_q <= (in_vidx == '0) ? AW'(MAX_DIM) : '0;
						if (j_start < n_eff) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (vec_last) begin
						e_q     <= '0;
						j_q     <= j_next;
						jbase_q <= jbase_next;
						if (j_next >= n_eff) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						e_q <= e_q + EW'(1);
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						if (held == '0) begin
							state_q <= ST_IDLE;
						end else begin
							out_valid_q <= 1'b1;
							out_idx_q   <= best_rd.idx;
							out_dist_q  <= best_rd.distance;
							out_last_q  <= (held == HW'(1));
							r_q         <= HW'(1);
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (out_last_q) begin
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							out_idx_q  <= best_rd.idx;
							out_dist_q <= best_rd.distance;
							out_last_q <= (r_q + HW'(1) == held);
							r_q        <= r_q + HW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	bfk_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (in_eval),
		.ra_addr(ra_addr),
		.ra_data(ra_data),
		.rb_addr(rb_addr),
		.rb_data(rb_data)
	);

	// s1: store data lands; s2: square; s3: accumulate and close a vector
	assign diff    = {1'b0, ra_data} - {1'b0, rb_data};
	assign mag     = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
	assign acc_sum = acc_q + ACC_W'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			use_s1   <= 1'b0;
			last_s1  <= 1'b0;
			idx_s1   <= '0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			idx_s2   <= '0;
			sq_s2    <= '0;
			acc_q    <= '0;
			cand_s3  <= '0;
		end else begin
			valid_s1 <= issue;
			use_s1   <= use_elem;
			last_s1  <= vec_last;
			idx_s1   <= IDX_W'(j_q);

			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			idx_s2   <= idx_s1;
			sq_s2    <= use_s1 ? SQ_W'(mag * mag) : '0;

			cand_s3.valid <= valid_s2 && last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					acc_q            <= '0;
					cand_s3.idx      <= idx_s2;
					cand_s3.distance <= (acc_sum > ACC_W'(DIST_MAX)) ? DIST_MAX
					                                                 : acc_sum[DIST_W-1:0];
				end else begin
					acc_q <= acc_sum;
				end
			end
		end
	end

	bfk_best #(
		.MAX_K(MAX_K)
	) u_best (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (query_go),
		.k     (k_eff),
		.cand  (cand_s3),
		.rd_sel(rd_sel),
		.rd    (best_rd),
		.held  (held)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_dist_q, out_idx_q};
	assign m_tlast  = out_last_q;

endmodule

[hw/rtl/bfk_ram.sv]
module bfk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    ra_addr,
	output logic [WIDTH-1:0] ra_data,
	input  logic [AW-1:0]    rb_addr,
	output logic [WIDTH-1:0] rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

[hw/rtl/bfk_best.sv]
module bfk_best import bfk_pkg::*; #(
	parameter int MAX_K = 16,
	localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1,
	localparam int HW = $clog2(MAX_K + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic [HW-1:0] k,
	input  cand_t         cand,
	input  logic [KW-1:0] rd_sel,
	output entry_t        rd,
	output logic [HW-1:0] held
);

	entry_t          list_q [MAX_K];
	entry_t          list_d [MAX_K];
	logic [HW-1:0]   held_q;
	logic [MAX_K-1:0] keep;
	logic            accepted;

	// sorted insert: entries at or below the new distance stay, the new one
	// lands just after them, the rest move down one place
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			keep[i] = (HW'(i) < held_q) && (list_q[i].distance <= cand.distance);
		end
		accepted = (held_q < k) || !keep[KW'(k - HW'(1))];
		for (int i = 0; i < MAX_K; i++) begin
			if (keep[i]) begin
				list_d[i] = list_q[i];
			end else if (i == 0) begin
				list_d[i] = '{distance: cand.distance, idx: cand.idx};
			end else if (keep[i-1]) begin
				list_d[i] = '{distance: cand.distance, idx: cand.idx};
			end else begin
				list_d[i] = list_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (clear) begin
			held_q <= '0;
		end else if (cand.valid && accepted && (held_q < k)) begin
			held_q <= held_q + HW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && cand.valid && accepted) begin
			list_q <= list_d;
		end
	end

	assign rd   = list_q[rd_sel];
	assign held = held_q;

endmodule

[test/tb_brute_force_knn_l2_top.sv]
// Self-checking bench for the brute-force k-nearest-neighbor block.
//
// Stimulus items sit in a queue that the initial block fills phase by phase.
// A clocked driver presents them one beat at a time. A clocked monitor checks
// every result beat against a queue of predicted neighbors. Prediction runs at
// the rising edge that accepts an input beat: a write updates the bench's own
// copy of the vector store, and a query runs the full exhaustive search on
// that copy. Inputs change on the falling edge and outputs are sampled on the
// rising edge, so nothing depends on event order inside a time step.
module tb_brute_force_knn_l2_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bfk_pkg::*;

	localparam int MAX_VEC = 1024;
	localparam int MAX_DIM = 128;
	localparam int MAX_K   = 16;

	// register index that decodes to nothing; its writes must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// one input beat: an element write or a neighbor query
	typedef struct packed {
		logic              action;
		logic [IDX_W-1:0]  vidx;
		logic [EIDX_W-1:0] eidx;
		logic [ELEM_W-1:0] evalue;
	} req_t;

	// one result beat: neighbor index, its distance and the end-of-query mark
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] distance;
		logic              last;
	} nbr_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;
	logic [0:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [39:0]           m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	brute_force_knn_l2_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Predictor state: its own copy of the store and the three registers.
	bit [ELEM_W-1:0]  vec_mem [MAX_VEC*MAX_DIM];
	logic [10:0]      reg_vcount;
	logic [7:0]       reg_dim;
	logic [4:0]       reg_k;

	// Generator-side record of which store entries have been queued for
	// writing; a query is only queued once everything it reads is covered.
	bit               gen_seen [MAX_VEC*MAX_DIM];

	req_t             pending [$];
	nbr_t             nbr_queue [$];
	req_t             cur;

	int unsigned      queued_cnt;
	int unsigned      accepted_cnt;
	int unsigned      writes_done;
	int unsigned      queries_done;
	int unsigned      beats_seen;
	int unsigned      settings_used;
	int unsigned      mismatches;

	bit               in_taken;
	bit               out_taken;
	bit               cfg_taken;
	int               gap_s;
	int               gap_m;
	int               calm_s;
	int               calm_m;

	function automatic int unsigned eff_n();
		return (reg_vcount > MAX_VEC) ? MAX_VEC : reg_vcount;
	endfunction

	function automatic int unsigned eff_dim();
		return (reg_dim > MAX_DIM) ? MAX_DIM : reg_dim;
	endfunction

	function automatic int unsigned eff_k();
		return (reg_k > MAX_K) ? MAX_K : reg_k;
	endfunction

	// Wait count before one beat. Mostly drawn from 0 to 18, with the odd run of
	// back-to-back beats so that full-rate stretches show up too.
	task automatic draw_wait(inout int calm, output int w);
		if (calm > 0) begin
			calm--;
			w = 0;
		end else begin
			if ($urandom_range(0, 24) == 0)
				calm = $urandom_range(5, 40);
			w = $urandom_range(0, 18);
		end
	endtask

	task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_VECTOR_COUNT:   reg_vcount = data;
			CFG_DIMENSION:      reg_dim = data[7:0];
			CFG_NEIGHBOR_COUNT: reg_k = data[4:0];
			default: ;
		endcase
	endtask

	// Exhaustive search over vectors in use, skipping the queried one. The
	// best list is kept sorted; candidates come in rising index order, so a
	// strict compare leaves ties with the lower index first.
	task automatic predict_query(input logic [IDX_W-1:0] q);
		int unsigned n;
		int unsigned dim;
		int unsigned k;
		int unsigned held;
		int unsigned pos;
		int unsigned acc;
		int          diff;
		int unsigned best_d [MAX_K];
		int unsigned best_i [MAX_K];
		nbr_t        nb;
		n = eff_n();
		dim = eff_dim();
		k = eff_k();
		held = 0;
		if (k != 0) begin
			for (int j = 0; j < n; j++) begin
				if (j == q)
					continue;
				acc = 0;
				for (int e = 0; e < dim; e++) begin
					diff = int'(vec_mem[q*MAX_DIM+e]) - int'(vec_mem[j*MAX_DIM+e]);
					acc += diff * diff;
				end
				if (acc > DIST_MAX)
					acc = 32'(DIST_MAX);
				if (held == k && acc >= best_d[k-1])
					continue;
				if (held == k) begin
					pos = k - 1;
				end else begin
					pos = held;
					held++;
				end
				while (pos > 0 && best_d[pos-1] > acc) begin
					best_d[pos] = best_d[pos-1];
					best_i[pos] = best_i[pos-1];
					pos--;
				end
				best_d[pos] = acc;
				best_i[pos] = j;
			end
			for (int r = 0; r < held; r++) begin
				nb.idx = IDX_W'(best_i[r]);
				nb.distance = DIST_W'(best_d[r]);
				nb.last = (r + 1 == held);
				nbr_queue.push_back(nb);
			end
		end
	endtask

	task automatic check_beat();
		nbr_t want;
		nbr_t got;
		got.idx = m_tdata[IDX_W-1:0];
		got.distance = m_tdata[IDX_W+DIST_W-1:IDX_W];
		got.last = m_tlast;
		beats_seen++;
		if (nbr_queue.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected result beat: index %0d distance %0d last %0b",
					got.idx, got.distance, got.last);
		end else begin
			want = nbr_queue.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: result beat %0d: expected index %0d distance %0d ",
						"last %0b, got index %0d distance %0d last %0b"},
						beats_seen, want.idx, want.distance, want.last,
						got.idx, got.distance, got.last);
			end
		end
	endtask

	// Rising edge: every handshake is seen here, and prediction and
	// checking happen on the beat that was actually accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_config(cfg_index, cfg_data);
				cfg_taken = 1'b1;
			end
			if (s_tvalid && s_tready) begin
				in_taken = 1'b1;
				accepted_cnt++;
				if (cur.action == ACT_WRITE) begin
					vec_mem[cur.vidx*MAX_DIM+cur.eidx] = cur.evalue;
					writes_done++;
				end else begin
					predict_query(cur.vidx);
					queries_done++;
				end
			end
			if (m_tvalid && m_tready) begin
				out_taken = 1'b1;
				check_beat();
			end
		end
	end

	// Input driver: holds a beat until accepted, then waits its drawn gap
	// before the next one. tvalid stays high across back-to-back beats.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (in_taken) begin
				in_taken = 1'b0;
				draw_wait(calm_s, gap_s);
			end
			if (gap_s > 0) begin
				gap_s--;
				s_tvalid <= 1'b0;
			end else if (pending.size() != 0) begin
				cur = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, cur.evalue, cur.eidx, cur.vidx};
				s_tuser <= cur.action;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side back-pressure: a fresh stall is drawn after each beat.
	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 1'b0;
			draw_wait(calm_m, gap_m);
		end
		if (gap_m > 0) begin
			gap_m--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		@(negedge clk);
		cfg_taken = 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DATA_W-1:0];
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input int unsigned vc, input int unsigned dm, input int unsigned nk);
		cfg_write(CFG_VECTOR_COUNT, vc);
		cfg_write(CFG_DIMENSION, dm);
		cfg_write(CFG_NEIGHBOR_COUNT, nk);
		settings_used++;
	endtask

	task automatic queue_item(input logic act, input int unsigned v, input int unsigned e,
			input int unsigned val);
		req_t it;
		it.action = act;
		it.vidx = IDX_W'(v);
		it.eidx = EIDX_W'(e);
		it.evalue = ELEM_W'(val);
		if (act == ACT_WRITE)
			gen_seen[v*MAX_DIM+e] = 1'b1;
		pending.push_back(it);
		queued_cnt++;
	endtask

	// Cover the elements in use of one vector. A fixed value overwrites,
	// a negative one fills only the gaps with random data.
	task automatic fill_vector(input int unsigned v, input int val);
		for (int e = 0; e < eff_dim(); e++)
			if (val >= 0 || !gen_seen[v*MAX_DIM+e])
				queue_item(ACT_WRITE, v, e, (val >= 0) ? val : $urandom_range(0, 255));
	endtask

	// A query reads every vector in use plus the queried one, so first make
	// sure all of those entries have been written.
	task automatic queue_query(input int unsigned q);
		for (int j = 0; j < eff_n(); j++)
			fill_vector(j, -1);
		fill_vector(q, -1);
		queue_item(ACT_QUERY, q, $urandom_range(0, 127), $urandom_range(0, 255));
	endtask

	// Drain: every beat accepted and every predicted result seen, then wait out
	// one full scan plus a margin for a query that produced nothing.
	task automatic settle();
		int unsigned spin;
		while (accepted_cnt != queued_cnt || nbr_queue.size() != 0)
			@(negedge clk);
		spin = eff_n() * ((eff_dim() == 0) ? 1 : eff_dim()) + 16;
		repeat (spin) @(negedge clk);
	endtask

	function automatic int unsigned pick_vector();
		if ($urandom_range(0, 5) == 0 || eff_n() == 0)
			return $urandom_range(0, MAX_VEC - 1);
		return $urandom_range(0, eff_n() - 1);
	endfunction

	initial begin
		int unsigned vc;
		int unsigned dm;
		int unsigned nk;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur = '0;
		reg_vcount = 11'd1024;
		reg_dim = 8'd128;
		reg_k = 5'd10;
		queued_cnt = 0;
		accepted_cnt = 0;
		writes_done = 0;
		queries_done = 0;
		beats_seen = 0;
		settings_used = 0;
		mismatches = 0;
		in_taken = 1'b0;
		out_taken = 1'b0;
		cfg_taken = 1'b0;
		gap_s = 0;
		gap_m = 0;
		calm_s = 0;
		calm_m = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two vectors at opposite extremes on every element in use: the
		// largest per-element difference. neighbor_count stays at reset.
		cfg_write(CFG_VECTOR_COUNT, 2);
		cfg_write(CFG_DIMENSION, 4);
		settings_used++;
		fill_vector(0, 255);
		fill_vector(1, 0);
		queue_query(0);
		queue_query(1);
		// queried vector beyond the count: nobody skipped, both vectors returned
		queue_query(MAX_VEC - 1);
		settle();

		// neighbor_count above the maximum saturates; one element per vector
		// and 8-bit values give plenty of ties.
		set_regs(20, 1, 31);
		queue_query(19);
		queue_query(0);
		queue_query(7);
		settle();

		// Zero dimension: every distance is zero, order falls back to index.
		set_regs(5, 0, 16);
		queue_query(3);
		settle();

		// Single vector in use: querying it finds nothing, querying past the
		// count still compares against vector 0.
		set_regs(1, 4, 16);
		queue_query(0);
		queue_query(5);
		settle();

		// No vectors in use, then no neighbors requested, then a write to
		// an index with no register behind it.
		set_regs(0, 4, 16);
		queue_query(0);
		settle();
		set_regs(6, 3, 0);
		cfg_write(CFG_UNUSED, $urandom_range(0, 2047));
		queue_query(2);
		settle();

		// Random phases up to about a hundred beats: small sets, mixed
		// writes and queries.
		while (queued_cnt < 100) begin
			vc = $urandom_range(2, 6);
			if ($urandom_range(0, 7) == 0)
				vc = $urandom_range(0, 1);
			dm = $urandom_range(1, 3);
			if ($urandom_range(0, 7) == 0)
				dm = 0;
			nk = $urandom_range(1, 16);
			case ($urandom_range(0, 9))
				0: nk = 0;
				1: nk = $urandom_range(17, 31);
				default: ;
			endcase
			set_regs(vc, dm, nk);
			for (int i = 0; i < 6; i++) begin
				if ($urandom_range(0, 9) < 4)
					queue_item(ACT_WRITE, pick_vector(),
						($urandom_range(0, 1) == 0 && eff_dim() != 0) ?
						$urandom_range(0, eff_dim() - 1) : $urandom_range(0, 127),
						$urandom_range(0, 255));
				else
					queue_query(pick_vector());
			end
			settle();
		end

		$display("Run covered %0d element writes and %0d queries over %0d register settings,",
			writes_done, queries_done, settings_used);
		$display("with %0d result beats checked and %0d mismatches.", beats_seen, mismatches);
		if (mismatches == 0 && nbr_queue.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
